[rtl/core/cma_pkg.sv]
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types and constants for the centered moving average unit.
// ----------------------------------------------------------------------------
package cma_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int WIN_W          = 6;
    localparam int SUM_W          = 38;
    localparam int CNT_W          = 32;
    localparam int DIV_CNT_W      = $clog2(SUM_W);
    localparam int DEF_MAX_WINDOW = 63;
    localparam int DEF_LINE_DEPTH = 64;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } cma_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smoothed;
        logic                       last_out;
    } cma_out_t;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [WIN_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] quotient;
    } div_rsp_t;

endpackage

[rtl/core/cma_divider.sv]
// ----------------------------------------------------------------------------
// cma_divider
// Iterative signed divider: window sum by sample count, one quotient bit per
// cycle, result truncated toward zero.
// ----------------------------------------------------------------------------
module cma_divider
    import cma_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 neg_reg, neg_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIN_W-1:0]     rem_reg, rem_next;
    logic [SUM_W-1:0]     q_reg, q_next;
    logic [WIN_W-1:0]     div_reg, div_next;

    logic [WIN_W:0]       trial;
    logic [WIN_W:0]       diff;
    logic                 ge;
    logic [SAMPLE_W-1:0]  q_lo;

    always_comb begin
        trial = {rem_reg, q_reg[SUM_W-1]};
        diff  = trial - {1'b0, div_reg};
        ge    = (trial >= {1'b0, div_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        div_next  = div_reg;

        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            neg_next  = req.dividend[SUM_W-1];
            // magnitude of the sum, never the most negative value
            q_next    = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend)
                                              : SUM_W'(req.dividend);
            div_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
            q_next   = {q_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        div_reg <= div_next;
    end

    assign q_lo         = q_reg[SAMPLE_W-1:0];
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(q_lo) : $signed(q_lo);

`ifndef SYNTHESIS
    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_start_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg && !done_reg)
        else $error("divider did not start");
`endif

endmodule

[rtl/core/centered_moving_average_unit.sv]
// ----------------------------------------------------------------------------
// centered_moving_average_unit
// Centered moving average with truncated edges over a stream of Q16.16
// samples, built around a delay-line memory and a single iterative divider.
// ----------------------------------------------------------------------------
// Each accepted word is stored in the delay line and then passes through a
// bookkeeping state. For every smoothed word, the n samples of its window,
// where n is the number of samples in the window, stream out of the single
// read port of the delay line into the adder, and the bit-serial divider
// then divides the sum by n. A non-final word yields at most one result once
// the look-ahead is filled. The final word of a series flushes the pending
// results, up to (w + 1)/2 of them for window length w, back to back, each
// through the same read and division. Window lengths of 0 or 1 pass words
// through without the delay line and the divider.
// The input is not ready while a word is being worked on; a finished result
// sits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module centered_moving_average_unit
    import cma_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int LINE_DEPTH = DEF_LINE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  cma_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output cma_out_t         m_data,
    input  logic             cfg_wr_en,
    input  logic [WIN_W-1:0] cfg_wr_data
);

    localparam int PTR_W = $clog2(LINE_DEPTH);
    localparam int AW    = ((PTR_W > WIN_W) ? PTR_W : WIN_W) + 1;
    localparam int CAP   = (MAX_WINDOW < LINE_DEPTH - 1) ? MAX_WINDOW : LINE_DEPTH - 1;
    localparam int HW    = WIN_W - 1;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_CHECK    = 9'b000000010,
        ST_START    = 9'b000000100,
        ST_ACCUM    = 9'b000001000,
        ST_DIV      = 9'b000010000,
        ST_DIV_WAIT = 9'b000100000,
        ST_RAW      = 9'b001000000,
        ST_RAW_WAIT = 9'b010000000,
        ST_EMIT     = 9'b100000000
    } state_t;

    state_t                     state_reg, state_next;
    logic [WIN_W-1:0]           window_len_reg, window_len_next;
    logic [CNT_W-1:0]           samples_reg, samples_next;
    logic [CNT_W-1:0]           outputs_reg, outputs_next;
    logic [PTR_W-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]           out_ptr_reg, out_ptr_next;
    logic [PTR_W-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [WIN_W-1:0]           issue_cnt_reg, issue_cnt_next;
    logic [WIN_W-1:0]           count_reg, count_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic                       inflight_reg, inflight_next;
    logic                       last_pend_reg, last_pend_next;
    logic signed [SAMPLE_W-1:0] res_reg, res_next;
    logic                       res_last_reg, res_last_next;
    logic                       out_valid_reg, out_valid_next;
    cma_out_t                   out_data_reg, out_data_next;

    logic [SAMPLE_W-1:0]        delay_line_reg [LINE_DEPTH];
    logic [SAMPLE_W-1:0]        rd_data_reg;

    logic [WIN_W-1:0]           eff_w;
    logic                       pass;
    logic [HW-1:0]              back;
    logic [HW-1:0]              ahead;
    logic [CNT_W-1:0]           pending;
    logic [CNT_W-1:0]           after;
    logic [HW-1:0]              nb;
    logic [HW-1:0]              na;
    logic [WIN_W-1:0]           win_cnt;
    logic [AW-1:0]              start_sum;
    logic [PTR_W-1:0]           start_ptr;
    logic                       s_accept;
    logic                       out_free;
    logic                       wr_en;
    logic                       rd_en;
    logic [PTR_W-1:0]           rd_addr;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(LINE_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    // effective window and its reach on either side
    assign eff_w = (int'(window_len_reg) > CAP) ? WIN_W'(CAP) : window_len_reg;
    assign pass  = (eff_w <= WIN_W'(1));
    assign back  = eff_w[WIN_W-1:1];
    assign ahead = eff_w[0] ? back : back - HW'(1);

    assign pending = samples_reg - outputs_reg;
    assign after   = pending - CNT_W'(1);
    assign nb      = (outputs_reg >= CNT_W'(back)) ? back : outputs_reg[HW-1:0];
    assign na      = (after >= CNT_W'(ahead)) ? ahead : after[HW-1:0];
    assign win_cnt = WIN_W'(nb) + WIN_W'(na) + WIN_W'(1);

    // ring slot of the oldest sample in the window
    assign start_sum = (AW'(out_ptr_reg) >= AW'(nb))
                     ? AW'(out_ptr_reg) - AW'(nb)
                     : AW'(out_ptr_reg) + AW'(LINE_DEPTH) - AW'(nb);
    assign start_ptr = start_sum[PTR_W-1:0];

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    assign wr_en   = s_accept && !pass;
    assign rd_en   = ((state_reg == ST_ACCUM) && (issue_cnt_reg != '0))
                   || (state_reg == ST_RAW);
    assign rd_addr = (state_reg == ST_RAW) ? out_ptr_reg : rd_ptr_reg;

    assign div_req.start    = (state_reg == ST_DIV);
    assign div_req.dividend = sum_reg;
    assign div_req.divisor  = count_reg;

    cma_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            delay_line_reg[wr_ptr_reg] <= s_data.sample;
        end
        if (rd_en) begin
            rd_data_reg <= delay_line_reg[rd_addr];
        end
    end

    always_comb begin
        state_next      = state_reg;
        window_len_next = window_len_reg;
        samples_next    = samples_reg;
        outputs_next    = outputs_reg;
        wr_ptr_next     = wr_ptr_reg;
        out_ptr_next    = out_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        issue_cnt_next  = issue_cnt_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        inflight_next   = (state_reg == ST_ACCUM) && (issue_cnt_reg != '0);
        last_pend_next  = last_pend_reg;
        res_next        = res_reg;
        res_last_next   = res_last_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_data_next   = out_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (pass) begin
                        res_next      = s_data.sample;
                        res_last_next = s_data.last;
                        state_next    = ST_EMIT;
                    end else begin
                        samples_next   = samples_reg + 1'b1;
                        wr_ptr_next    = ptr_inc(wr_ptr_reg);
                        last_pend_next = s_data.last;
                        state_next     = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (last_pend_reg) begin
                    if (pending == '0) begin
                        // series done, start over
                        samples_next   = '0;
                        outputs_next   = '0;
                        wr_ptr_next    = '0;
                        out_ptr_next   = '0;
                        last_pend_next = 1'b0;
                        state_next     = ST_IDLE;
                    end else begin
                        res_last_next = (pending == CNT_W'(1));
                        // series too short to smooth: stored words leave as they are
                        state_next    = (samples_reg < CNT_W'(ahead)) ? ST_RAW : ST_START;
                    end
                end else if (pending > CNT_W'(ahead)) begin
                    res_last_next = 1'b0;
                    state_next    = ST_START;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_START: begin
                rd_ptr_next    = start_ptr;
                issue_cnt_next = win_cnt;
                count_next     = win_cnt;
                sum_next       = '0;
                state_next     = ST_ACCUM;
            end
            ST_ACCUM: begin
                if (issue_cnt_reg != '0) begin
                    rd_ptr_next    = ptr_inc(rd_ptr_reg);
                    issue_cnt_next = issue_cnt_reg - 1'b1;
                end
                // read data lands in the cycle after its address
                if (inflight_reg) begin
                    sum_next = sum_reg + $signed({{(SUM_W-SAMPLE_W){rd_data_reg[SAMPLE_W-1]}},
                                                  rd_data_reg});
                end
                if ((issue_cnt_reg == '0) && !inflight_reg) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    res_next   = div_rsp.quotient;
                    state_next = ST_EMIT;
                end
            end
            ST_RAW: begin
                state_next = ST_RAW_WAIT;
            end
            ST_RAW_WAIT: begin
                res_next   = $signed(rd_data_reg);
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next         = 1'b1;
                    out_data_next.smoothed = res_reg;
                    out_data_next.last_out = res_last_reg;
                    if (pass) begin
                        state_next = ST_IDLE;
                    end else begin
                        outputs_next = outputs_reg + 1'b1;
                        out_ptr_next = ptr_inc(out_ptr_reg);
                        state_next   = ST_CHECK;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a new window length drops the series in progress
        if (cfg_wr_en) begin
            window_len_next = cfg_wr_data;
            samples_next    = '0;
            outputs_next    = '0;
            wr_ptr_next     = '0;
            out_ptr_next    = '0;
            last_pend_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            window_len_reg <= WIN_W'(1);
            samples_reg    <= '0;
            outputs_reg    <= '0;
            wr_ptr_reg     <= '0;
            out_ptr_reg    <= '0;
            issue_cnt_reg  <= '0;
            inflight_reg   <= 1'b0;
            last_pend_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            window_len_reg <= window_len_next;
            samples_reg    <= samples_next;
            outputs_reg    <= outputs_next;
            wr_ptr_reg     <= wr_ptr_next;
            out_ptr_reg    <= out_ptr_next;
            issue_cnt_reg  <= issue_cnt_next;
            inflight_reg   <= inflight_next;
            last_pend_reg  <= last_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg   <= rd_ptr_next;
        count_reg    <= count_next;
        sum_reg      <= sum_next;
        res_reg      <= res_next;
        res_last_reg <= res_last_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTHESIS
    a_emit_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) && !pass |-> samples_reg != outputs_reg)
        else $error("result word with no pending sample");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (count_reg != '0) && (count_reg <= eff_w))
        else $error("window count out of range");

    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished while not awaited");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for centered_moving_average_unit. A behavioral copy of
// the smoother predicts every result; a scoreboard compares the output words
// in order while both handshakes idle at random and the window length moves
// between pass-through, short, even, odd and the widest setting.
// ----------------------------------------------------------------------------
module tb;
    import cma_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_CYCLES  = 256;
    localparam int REPORT_MAX    = 10;
    localparam int LINE_AW       = $clog2(DEF_LINE_DEPTH);

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    cma_in_t          s_data      = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    cma_out_t         m_data;
    logic             cfg_wr_en   = 1'b0;
    logic [WIN_W-1:0] cfg_wr_data = '0;

    // predictor state
    logic signed [SAMPLE_W-1:0] line_mem [DEF_LINE_DEPTH];
    int unsigned                seen_cnt;
    int unsigned                sent_cnt;
    logic [WIN_W-1:0]           win_len;
    cma_out_t                   expected_words [$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int unsigned cycle_count    = 0;
    int unsigned sent_words     = 0;
    int unsigned checked_words  = 0;
    int unsigned mismatch_count = 0;
    int unsigned window_writes  = 0;

    centered_moving_average_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_words.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void clear_series();
        seen_cnt = 0;
        sent_cnt = 0;
    endfunction

    // ring slot of a sample number
    function automatic logic [LINE_AW-1:0] slot(input int unsigned n);
        return LINE_AW'(n % DEF_LINE_DEPTH);
    endfunction

    // mean of the window around pos, cut to the samples stored so far
    function automatic logic signed [SAMPLE_W-1:0] window_mean(input int unsigned pos,
                                                               input int unsigned back,
                                                               input int unsigned ahead);
        longint                     total;
        longint                     terms;
        int unsigned                later;
        int unsigned                k;
        logic signed [SAMPLE_W-1:0] mean;
        later = seen_cnt - pos - 1;
        total = line_mem[slot(pos)];
        terms = 1;
        for (k = 1; k <= back; k++) begin
            if (pos >= k) begin
                total += line_mem[slot(pos - k)];
                terms++;
            end
        end
        for (k = 1; k <= ahead; k++) begin
            if (k <= later) begin
                total += line_mem[slot(pos + k)];
                terms++;
            end
        end
        mean = SAMPLE_W'(total / terms);
        return mean;
    endfunction

    function automatic void predict_smoothing(input cma_in_t word);
        int unsigned win;
        int unsigned back;
        int unsigned ahead;
        bit          short_series;
        cma_out_t    res;
        win = win_len;
        if (win > DEF_MAX_WINDOW) win = DEF_MAX_WINDOW;
        if (win > DEF_LINE_DEPTH - 1) win = DEF_LINE_DEPTH - 1;
        if (win <= 1) begin
            res.smoothed = word.sample;
            res.last_out = word.last;
            expected_words.push_back(res);
            if (word.last) begin
                clear_series();
            end else begin
                seen_cnt++;
                sent_cnt++;
            end
            return;
        end
        back  = win / 2;
        ahead = (win % 2) ? back : back - 1;
        line_mem[slot(seen_cnt)] = word.sample;
        seen_cnt++;
        if (!word.last) begin
            while (seen_cnt - sent_cnt > ahead) begin
                res.smoothed = window_mean(sent_cnt, back, ahead);
                res.last_out = 1'b0;
                expected_words.push_back(res);
                sent_cnt++;
            end
            return;
        end
        // series too short to fill the look-ahead leaves unchanged
        short_series = (seen_cnt < ahead);
        while (sent_cnt != seen_cnt) begin
            res.smoothed = short_series ? line_mem[slot(sent_cnt)]
                                        : window_mean(sent_cnt, back, ahead);
            res.last_out = (sent_cnt + 1 == seen_cnt);
            expected_words.push_back(res);
            sent_cnt++;
        end
        clear_series();
    endfunction

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        cma_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected word: smoothed %h last_out %b",
                             m_data.smoothed, m_data.last_out);
            end else begin
                want = expected_words.pop_front();
                checked_words++;
                if (m_data.smoothed !== want.smoothed || m_data.last_out !== want.last_out) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("word %0d: expected smoothed %h last_out %b, got %h %b",
                                 checked_words, want.smoothed, want.last_out,
                                 m_data.smoothed, m_data.last_out);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_word(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
        cma_in_t word;
        word.sample = smp;
        word.last   = lst;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_smoothing(word);
        sent_words++;
    endtask

    // hold off until every expected word is back and the block has settled
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] len);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        win_len = len;
        clear_series();
        window_writes++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0000_0000;
                    default: return 32'shFFFF_FFFF;
                endcase
            end
            1, 2: return $signed($urandom_range(2000)) - 1000;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_pass_through();
        // window of one after reset
        send_word(32'sh7FFF_FFFF, 1'b0);
        send_word(32'sh8000_0000, 1'b1);
        send_word(32'sh0000_0000, 1'b0);
        send_word(32'shFFFF_FFFF, 1'b1);
    endtask

    task automatic test_window_zero();
        write_window(6'd0);
        send_word(32'sh1234_5678, 1'b0);
        send_word(32'shEDCB_A988, 1'b1);
    endtask

    task automatic test_short_series();
        write_window(6'd9);
        send_word(32'sh0001_8000, 1'b1);
        send_word(32'sh7FFF_FFFF, 1'b0);
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'sh0000_0003, 1'b1);
        write_window(6'd63);
        send_word(-32'sh0002_0000, 1'b0);
        send_word(32'sh0005_4321, 1'b1);
    endtask

    task automatic test_even_windows();
        write_window(6'd2);
        send_word(32'sh7FFF_FFFF, 1'b0);
        send_word(32'sh7FFF_FFFF, 1'b0);
        send_word(-32'sh0000_0003, 1'b1);
        write_window(6'd4);
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'sh0000_0007, 1'b0);
        send_word(-32'sh0000_0001, 1'b1);
    endtask

    task automatic test_drop_on_write();
        // words still inside the look-ahead are lost on a window write
        write_window(6'd5);
        send_word(32'sh0100_0000, 1'b0);
        send_word(32'sh0200_0000, 1'b0);
        write_window(6'd3);
        send_word(32'sh0000_0010, 1'b0);
        send_word(-32'sh0000_0021, 1'b0);
        send_word(32'sh0000_0005, 1'b1);
    endtask

    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                       input int unsigned budget);
        int unsigned done_words;
        int unsigned len;
        int unsigned i;
        bit          broken;
        bit          fresh_window;
        logic [WIN_W-1:0] new_len;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        done_words    = 0;
        broken        = 1'b0;
        while (done_words < budget) begin
            fresh_window = broken || ($urandom_range(2) == 0);
            if (fresh_window) begin
                case ($urandom_range(7))
                    0: new_len = 6'd63;
                    1: new_len = WIN_W'($urandom_range(1));
                    2: new_len = WIN_W'($urandom_range(63));
                    default: new_len = WIN_W'($urandom_range(12, 2));
                endcase
                write_window(new_len);
            end
            if (win_len == 6'd63 && $urandom_range(2) == 0)
                len = 40;
            else
                len = $urandom_range(win_len + 4, 1);
            if (len > 14 && win_len != 6'd63)
                len = 14;
            // an occasional series that never sees its last word
            broken = ($urandom_range(5) == 0);
            for (i = 0; i < len; i++) begin
                if ($urandom_range(19) == 0)
                    wait_drained();
                send_word(random_sample(), (i == len - 1) && !broken);
                done_words++;
            end
        end
        wait_drained();
    endtask

    initial begin
        foreach (line_mem[j]) line_mem[j] = '0;
        win_len = 6'd1;
        clear_series();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_pass_through();
        test_window_zero();
        test_short_series();
        test_even_windows();
        test_drop_on_write();
        test_random_traffic(32, 72, 30);
        test_random_traffic(72, 32, 30);
        test_random_traffic(0, 0, 30);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d sample words over %0d window settings, checked %0d results",
                 sent_words, window_writes + 1, checked_words);
        $display("mismatches %0d, results never seen %0d", mismatch_count,
                 expected_words.size());
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
